/* hw/rtl/lhc_pkg.sv */
// Shared constants for the LZSS hash compressor.
`timescale 1ns / 1ps
`default_nettype none
package lhc_pkg;

	// Default configuration
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int MIN_MATCH_DEF   = 3;
	localparam int MAX_MATCH_DEF   = 18;
	localparam int POS_WIDTH_DEF   = 24;

	// Token field limits
	localparam int DIST_FIELD_MAX  = 4095;
	localparam int GROUP_ITEMS     = 8;
	localparam int GROUP_BYTES     = 16;

endpackage
`default_nettype wire

/* hw/rtl/lzss_hash_compressor.sv */
// LZSS compressor top level: hash lookup, match compare, group packing.
// Flow: an item is accepted, then a decision is made; once MAX_MATCH+MIN_MATCH-1 bytes
//   are pending (or at stream end), coding reads the hash table, checks a candidate,
//   compares history bytes up to the first mismatch, writes a token and consumes bytes;
//   a full group (or the final partial one) is emitted byte by byte. One input item at a time.
// Reset: asynchronous, active low; afterwards and after every stream end the hash
//   table is swept clear while no input item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module lzss_hash_compressor #(
	parameter int WINDOW_SIZE = lhc_pkg::WINDOW_SIZE_DEF,
	parameter int MIN_MATCH   = lhc_pkg::MIN_MATCH_DEF,
	parameter int MAX_MATCH   = lhc_pkg::MAX_MATCH_DEF,
	parameter int POS_WIDTH   = lhc_pkg::POS_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  wire logic       s_axis_tlast,  // in_last
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tlast   // out_last
);

	localparam int LA_CAP   = MAX_MATCH + MIN_MATCH - 1;
	localparam int CW       = $clog2(LA_CAP + 1);
	localparam int IW       = $clog2(LA_CAP);
	localparam int LW       = $clog2(MAX_MATCH + 1);
	localparam int AW       = $clog2(WINDOW_SIZE);
	localparam int MAX_DIST = (WINDOW_SIZE < lhc_pkg::DIST_FIELD_MAX + 1) ?
		WINDOW_SIZE : lhc_pkg::DIST_FIELD_MAX;
	localparam int DW       = $clog2(MAX_DIST + 1);
	localparam int PW       = POS_WIDTH + 1;
	localparam int HW       = POS_WIDTH + 1;
	localparam logic [PW-1:0] POS_LIMIT = {1'b1, {POS_WIDTH{1'b0}}};
	localparam int GW       = $clog2(lhc_pkg::GROUP_BYTES + 1);
	localparam int GIW      = $clog2(lhc_pkg::GROUP_BYTES);

	// State codes
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_HREAD  = 4'd3;
	localparam logic [3:0] S_HCHK   = 4'd4;
	localparam logic [3:0] S_CMP0   = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_TOKEN  = 4'd7;
	localparam logic [3:0] S_CONS   = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	// 3-byte hash into the table index range
	function automatic logic [AW-1:0] hash3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [17:0] v;
		v = (18'(a) * 18'd31 + 18'(b)) * 18'd31 + 18'(c);
		return AW'(v & 18'(WINDOW_SIZE - 1));
	endfunction

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    la_q [LA_CAP];
	logic [CW-1:0] cnt_q;
	logic          flush_q;
	logic [PW-1:0] pos_q;
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] h_q;
	logic [DW-1:0] dist_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] ra_q;
	logic [DW-1:0] off_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] maxlen_q;
	logic [LW-1:0] best_q;
	logic [LW-1:0] k_q;
	logic          ins_q;
	logic [7:0]    gb_q [lhc_pkg::GROUP_BYTES];
	logic [GW-1:0] gcnt_q;
	logic [7:0]    flags_q;
	logic [3:0]    items_q;
	logic [GW-1:0] idx_q;
	logic          elast_q;
	logic          ov_q;
	logic [7:0]    od_q;
	logic          ol_q;

	logic [AW-1:0] h_cur;
	logic          hw_en;
	logic [AW-1:0] hw_addr;
	logic [HW-1:0] hw_data;
	logic [HW-1:0] hr_data;
	logic          xw_en;
	logic [7:0]    xr_data;

	logic              c_vld;
	logic [PW-1:0]     c_pos;
	logic [PW-1:0]     c_diff;
	logic              c_ok;
	logic [AW:0]       c_dist;
	logic [AW:0]       c_start;
	logic [LW-1:0]     c_maxlen;
	logic [DW-1:0]     off_nxt;
	logic              pos_live;
	logic              out_free;
	logic [11:0]       dist12;

	assign h_cur    = hash3(la_q[0], la_q[1], la_q[2]);
	assign pos_live = pos_q < POS_LIMIT;
	assign out_free = !ov_q || m_axis_tready;
	assign dist12   = 12'(dist_q);

	// Candidate check from the hash table entry
	always_comb begin
		c_vld    = hr_data[HW-1];
		c_pos    = PW'(hr_data[POS_WIDTH-1:0]);
		c_diff   = pos_q - c_pos;
		c_ok     = c_vld && (c_pos < pos_q) && (c_diff <= PW'(MAX_DIST));
		c_dist   = (AW+1)'(c_diff);
		c_start  = ({1'b0, wptr_q} >= c_dist) ? ({1'b0, wptr_q} - c_dist) :
			({1'b0, wptr_q} + (AW+1)'(WINDOW_SIZE) - c_dist);
		c_maxlen = (cnt_q < CW'(MAX_MATCH)) ? LW'(cnt_q) : LW'(MAX_MATCH);
		off_nxt  = off_q + DW'(1);
	end

	// Hash table write port: clear sweep, lookup update, covered-position insert
	always_comb begin
		hw_en   = 1'b0;
		hw_addr = h_cur;
		hw_data = {1'b1, pos_q[POS_WIDTH-1:0]};
		case (state_q)
			S_CLEAR: begin
				hw_en   = 1'b1;
				hw_addr = clr_q;
				hw_data = '0;
			end
			S_HCHK: begin
				hw_en   = 1'b1;
				hw_addr = h_q;
			end
			S_CONS: begin
				hw_en = ins_q && (k_q != '0) && (cnt_q >= CW'(MIN_MATCH)) && pos_live;
			end
			default: begin
				hw_en = 1'b0;
			end
		endcase
	end

	assign xw_en = (state_q == S_CONS) && (k_q != '0) && (cnt_q != '0);

	lhc_ram #(.WIDTH(HW), .DEPTH(WINDOW_SIZE)) u_hash_ram (
		.clk     (clk),
		.wr_en   (hw_en),
		.wr_addr (hw_addr),
		.wr_data (hw_data),
		.rd_addr (h_cur),
		.rd_data (hr_data)
	);

	lhc_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_hist_ram (
		.clk     (clk),
		.wr_en   (xw_en),
		.wr_addr (wptr_q),
		.wr_data (la_q[0]),
		.rd_addr (ra_q),
		.rd_data (xr_data)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tlast  = ol_q;

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && cnt_q < CW'(LA_CAP)) begin
					la_q[IW'(cnt_q)] <= s_axis_tdata;
				end
			end
			S_HREAD: begin
				h_q <= h_cur;
			end
			S_HCHK: begin
				dist_q   <= DW'(c_diff);
				start_q  <= AW'(c_start);
				ra_q     <= AW'(c_start);
				off_q    <= '0;
				maxlen_q <= c_maxlen;
			end
			S_CMP0, S_CMP: begin
				if (off_nxt == dist_q) begin
					off_q <= '0;
					ra_q  <= start_q;
				end else begin
					off_q <= off_nxt;
					ra_q  <= (ra_q == AW'(WINDOW_SIZE - 1)) ? '0 : ra_q + AW'(1);
				end
			end
			S_TOKEN: begin
				if (best_q >= LW'(MIN_MATCH)) begin
					gb_q[GIW'(gcnt_q)]          <= dist12[7:0];
					gb_q[GIW'(gcnt_q + GW'(1))] <= {dist12[11:8],
						4'(best_q - LW'(MIN_MATCH))};
				end else begin
					gb_q[GIW'(gcnt_q)] <= la_q[0];
				end
			end
			S_CONS: begin
				if (k_q != '0 && cnt_q != '0) begin
					for (int i = 0; i < LA_CAP - 1; i++) begin
						la_q[i] <= la_q[i + 1];
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					od_q <= (idx_q == '0) ? flags_q : gb_q[GIW'(idx_q - GW'(1))];
					ol_q <= elast_q && (idx_q == gcnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			flush_q  <= 1'b0;
			pos_q    <= '0;
			wptr_q   <= '0;
			len_q    <= '0;
			best_q   <= '0;
			k_q      <= '0;
			ins_q    <= 1'b0;
			gcnt_q   <= '0;
			flags_q  <= '0;
			items_q  <= '0;
			idx_q    <= '0;
			elast_q  <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WINDOW_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (cnt_q < CW'(LA_CAP)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						flush_q <= s_axis_tlast;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (flush_q) begin
						if (cnt_q != '0) begin
							state_q <= S_HREAD;
						end else if (items_q != '0) begin
							idx_q   <= '0;
							elast_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							// end of stream: back to a fresh stream
							flush_q <= 1'b0;
							pos_q   <= '0;
							wptr_q  <= '0;
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end
					end else if (cnt_q == CW'(LA_CAP)) begin
						state_q <= S_HREAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_HREAD: begin
					best_q <= '0;
					if (pos_live && cnt_q >= CW'(MIN_MATCH)) begin
						state_q <= S_HCHK;
					end else begin
						state_q <= S_TOKEN;
					end
				end
				S_HCHK: begin
					state_q <= c_ok ? S_CMP0 : S_TOKEN;
				end
				S_CMP0: begin
					len_q   <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// one history byte compared per cycle
					if (xr_data == la_q[IW'(len_q)]) begin
						if (len_q + LW'(1) == maxlen_q) begin
							best_q  <= maxlen_q;
							state_q <= S_TOKEN;
						end else begin
							len_q <= len_q + LW'(1);
						end
					end else begin
						best_q  <= len_q;
						state_q <= S_TOKEN;
					end
				end
				S_TOKEN: begin
					if (best_q >= LW'(MIN_MATCH)) begin
						gcnt_q <= gcnt_q + GW'(2);
						k_q    <= best_q;
						ins_q  <= 1'b1;
					end else begin
						gcnt_q  <= gcnt_q + GW'(1);
						flags_q <= flags_q | (8'h80 >> items_q[2:0]);
						k_q     <= LW'(1);
						ins_q   <= 1'b0;
					end
					state_q <= S_CONS;
				end
				S_CONS: begin
					if (k_q != '0 && cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
						k_q   <= k_q - LW'(1);
						if (pos_live) begin
							pos_q  <= pos_q + PW'(1);
							wptr_q <= (wptr_q == AW'(WINDOW_SIZE - 1)) ? '0 :
								wptr_q + AW'(1);
						end
					end else begin
						items_q <= items_q + 4'd1;
						if (items_q == 4'(lhc_pkg::GROUP_ITEMS - 1)) begin
							idx_q   <= '0;
							elast_q <= flush_q && (cnt_q == '0);
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						if (idx_q == gcnt_q) begin
							gcnt_q  <= '0;
							flags_q <= '0;
							items_q <= '0;
							state_q <= S_DECIDE;
						end else begin
							idx_q <= idx_q + GW'(1);
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lhc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

/* hw/rtl/lhc_checker.sv */
// Port-level checker for the LZSS hash compressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lhc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	// One item in work at a time: accepting an item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while previous item in work");

	// A final source byte keeps the input closed while it flushes
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input reopened during flush");

	// Stalled output item keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	// Stalled output item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

endmodule

bind lzss_hash_compressor lhc_checker u_lhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
